>>> rtl/lrast_pkg.sv
// Package for the line rasterizer: widths, register indexes, request codes
// and the packed request, pixel and line state types.
// No dependencies; every other file of the block uses it.
package lrast_pkg;

    localparam int COORD_BITS = 16;
    localparam int DIM_BITS = 15;
    localparam int CMP_BITS = ((COORD_BITS > DIM_BITS) ? COORD_BITS : DIM_BITS) + 1;
    localparam int SUM_BITS = COORD_BITS + 2;
    localparam int CFG_INDEX_BITS = 1;

    localparam logic [DIM_BITS-1:0] WIDTH_RESET = DIM_BITS'(640);
    localparam logic [DIM_BITS-1:0] HEIGHT_RESET = DIM_BITS'(480);

    localparam logic [CFG_INDEX_BITS-1:0] REG_SCREEN_WIDTH = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_SCREEN_HEIGHT = CFG_INDEX_BITS'(1);

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_ADVANCE = 1'b1;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic [COORD_BITS-1:0] span_t;
    typedef logic signed [COORD_BITS:0] delta_t;
    typedef logic [7:0] chan_t;
    typedef logic [DIM_BITS-1:0] dim_t;

    typedef struct packed {
        logic   kind;
        coord_t x_start;
        coord_t y_start;
        coord_t x_end;
        coord_t y_end;
        chan_t  red_in;
        chan_t  green_in;
        chan_t  blue_in;
        chan_t  alpha_in;
    } req_t;

    typedef struct packed {
        coord_t pixel_x;
        coord_t pixel_y;
        chan_t  red_out;
        chan_t  green_out;
        chan_t  blue_out;
        chan_t  alpha_out;
        logic   last_pixel;
    } rsp_t;

    typedef struct packed {
        logic   active;
        logic   major_is_y;
        coord_t position;
        coord_t limit;
        span_t  span;
        delta_t delta;
        coord_t quotient;
        span_t  remainder;
        chan_t  red;
        chan_t  green;
        chan_t  blue;
        chan_t  alpha;
    } line_state_t;

endpackage

>>> rtl/lrast_setup.sv
// Line set-up: screen reject test, major axis choice, endpoint ordering.
// Produces the line state for a load request. Uses lrast_pkg.
module lrast_setup (
    input  lrast_pkg::req_t        req,
    input  lrast_pkg::dim_t        screen_width,
    input  lrast_pkg::dim_t        screen_height,
    output lrast_pkg::line_state_t line
);

    localparam int CB = lrast_pkg::COORD_BITS;
    localparam int XB = lrast_pkg::CMP_BITS - CB;
    localparam int WB = lrast_pkg::CMP_BITS - lrast_pkg::DIM_BITS;

    logic signed [lrast_pkg::CMP_BITS-1:0] x1_c, y1_c, x2_c, y2_c, w_c, h_c;
    logic              reject;
    lrast_pkg::delta_t dx, dy, neg_dx, neg_dy, span_full;
    lrast_pkg::span_t  mag_x, mag_y;
    logic              major_is_y;
    lrast_pkg::coord_t a1, b1, a2, b2, pos, lim, b_lo, b_hi;

    always_comb
    begin
        x1_c = $signed({{XB{req.x_start[CB-1]}}, req.x_start});
        y1_c = $signed({{XB{req.y_start[CB-1]}}, req.y_start});
        x2_c = $signed({{XB{req.x_end[CB-1]}}, req.x_end});
        y2_c = $signed({{XB{req.y_end[CB-1]}}, req.y_end});
        w_c = $signed({{WB{1'b0}}, screen_width});
        h_c = $signed({{WB{1'b0}}, screen_height});

        reject = (req.x_start[CB-1] && req.x_end[CB-1])
              || (x1_c > w_c && x2_c > w_c)
              || (req.y_start[CB-1] && req.y_end[CB-1])
              || (y1_c > h_c && y2_c > h_c);

        dx = $signed({req.x_end[CB-1], req.x_end}) - $signed({req.x_start[CB-1], req.x_start});
        dy = $signed({req.y_end[CB-1], req.y_end}) - $signed({req.y_start[CB-1], req.y_start});
        neg_dx = -dx;
        neg_dy = -dy;
        mag_x = dx[CB] ? neg_dx[CB-1:0] : dx[CB-1:0];
        mag_y = dy[CB] ? neg_dy[CB-1:0] : dy[CB-1:0];
        major_is_y = mag_x < mag_y;

        a1 = major_is_y ? req.y_start : req.x_start;
        b1 = major_is_y ? req.x_start : req.y_start;
        a2 = major_is_y ? req.y_end : req.x_end;
        b2 = major_is_y ? req.x_end : req.y_end;

        if ($signed(a1) <= $signed(a2))
        begin
            pos = a1;
            lim = a2;
            b_lo = b1;
            b_hi = b2;
        end
        else
        begin
            pos = a2;
            lim = a1;
            b_lo = b2;
            b_hi = b1;
        end

        span_full = $signed({lim[CB-1], lim}) - $signed({pos[CB-1], pos});

        line.active = !reject;
        line.major_is_y = major_is_y;
        line.position = pos;
        line.limit = lim;
        line.span = span_full[CB-1:0];
        line.delta = $signed({b_hi[CB-1], b_hi}) - $signed({b_lo[CB-1], b_lo});
        line.quotient = b_lo;
        line.remainder = '0;
        line.red = req.red_in;
        line.green = req.green_in;
        line.blue = req.blue_in;
        line.alpha = req.alpha_in;
    end

endmodule

>>> rtl/lrast_step.sv
// Pixel step: rounds the minor coordinate, forms the pixel and advances
// the quotient and remainder by one major step. Uses lrast_pkg.
module lrast_step (
    input  lrast_pkg::line_state_t cur,
    output lrast_pkg::rsp_t        pix,
    output lrast_pkg::line_state_t nxt
);

    localparam int CB = lrast_pkg::COORD_BITS;
    localparam int SB = lrast_pkg::SUM_BITS;

    logic [CB:0]                 twice, span_x;
    logic                        round_up, last;
    lrast_pkg::coord_t           minor;
    logic signed [SB-1:0]        sum, span_s, sum_hi, sum_lo;

    always_comb
    begin
        twice = {cur.remainder, 1'b0};
        span_x = {1'b0, cur.span};
        round_up = (cur.span != '0)
                && ((twice > span_x) || (twice == span_x && !cur.quotient[CB-1]));
        minor = cur.quotient + {{(CB-1){1'b0}}, round_up};
        last = cur.position == cur.limit;

        pix.pixel_x = cur.major_is_y ? minor : cur.position;
        pix.pixel_y = cur.major_is_y ? cur.position : minor;
        pix.red_out = cur.red;
        pix.green_out = cur.green;
        pix.blue_out = cur.blue;
        pix.alpha_out = cur.alpha;
        pix.last_pixel = last;

        sum = $signed({2'b00, cur.remainder}) + $signed({cur.delta[CB], cur.delta});
        span_s = $signed({2'b00, cur.span});
        sum_hi = sum - span_s;
        sum_lo = sum + span_s;

        nxt = cur;
        if (last)
        begin
            nxt.active = 1'b0;
        end
        else
        begin
            nxt.position = cur.position + {{(CB-1){1'b0}}, 1'b1};
            if (sum >= span_s)
            begin
                nxt.remainder = sum_hi[CB-1:0];
                nxt.quotient = cur.quotient + {{(CB-1){1'b0}}, 1'b1};
            end
            else if (sum[SB-1])
            begin
                nxt.remainder = sum_lo[CB-1:0];
                nxt.quotient = cur.quotient - {{(CB-1){1'b0}}, 1'b1};
            end
            else
            begin
                nxt.remainder = sum[CB-1:0];
            end
        end
    end

endmodule

>>> rtl/line_rasterizer.sv
// An advance request is taken into req_reg; its pixel is registered in rsp_reg when the
// request leaves req_reg. Throughput: one request per cycle unless an advance waits
// behind a stalled pixel; the rate is set by the combinational step unit that updates the line state.
// Reset (rst_n low, asynchronous) empties both registers, drops the active line,
// and sets the screen width to 640 and the height to 480.
module line_rasterizer (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 req_valid,
    output logic                                 req_ready,
    input  lrast_pkg::req_t                      req,
    output logic                                 rsp_valid,
    input  logic                                 rsp_ready,
    output lrast_pkg::rsp_t                      rsp,
    input  logic                                 cfg_we,
    input  logic [lrast_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  lrast_pkg::dim_t                      cfg_data
);

    lrast_pkg::req_t        req_reg;
    logic                   req_valid_reg, req_valid_next;
    lrast_pkg::rsp_t        rsp_reg;
    logic                   rsp_valid_reg, rsp_valid_next;
    lrast_pkg::line_state_t line_reg, line_next;
    lrast_pkg::dim_t        width_reg, height_reg;
    lrast_pkg::line_state_t setup_line, step_line;
    lrast_pkg::rsp_t        step_pix;
    logic                   emits, consume;

    lrast_setup u_setup (
        .req           (req_reg),
        .screen_width  (width_reg),
        .screen_height (height_reg),
        .line          (setup_line)
    );

    lrast_step u_step (
        .cur (line_reg),
        .pix (step_pix),
        .nxt (step_line)
    );

    always_comb
    begin
        emits = req_valid_reg && (req_reg.kind == lrast_pkg::KIND_ADVANCE) && line_reg.active;
        consume = req_valid_reg && (!emits || !rsp_valid_reg || rsp_ready);
        req_ready = !req_valid_reg || consume;

        if (req_ready)
        begin
            req_valid_next = req_valid;
        end
        else
        begin
            req_valid_next = req_valid_reg;
        end

        line_next = line_reg;
        if (consume)
        begin
            if (req_reg.kind == lrast_pkg::KIND_LOAD)
            begin
                line_next = setup_line;
            end
            else if (line_reg.active)
            begin
                line_next = step_line;
            end
        end

        if (consume && emits)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end

        rsp_valid = rsp_valid_reg;
        rsp = rsp_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
            line_reg <= '0;
            width_reg <= lrast_pkg::WIDTH_RESET;
            height_reg <= lrast_pkg::HEIGHT_RESET;
        end
        else
        begin
            req_valid_reg <= req_valid_next;
            rsp_valid_reg <= rsp_valid_next;
            line_reg <= line_next;
            if (cfg_we && cfg_index == lrast_pkg::REG_SCREEN_WIDTH)
            begin
                width_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == lrast_pkg::REG_SCREEN_HEIGHT)
            begin
                height_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_ready)
        begin
            req_reg <= req;
        end
        if (consume && emits)
        begin
            rsp_reg <= step_pix;
        end
    end

endmodule

>>> rtl/lrast_checker.sv
// Port checker for the line rasterizer, attached to the top level by bind.
// Uses lrast_pkg and watches only the ports of line_rasterizer.
module lrast_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            req_valid,
    input logic            req_ready,
    input lrast_pkg::req_t req,
    input logic            rsp_valid,
    input logic            rsp_ready,
    input lrast_pkg::rsp_t rsp
);

    // A stalled pixel must hold its value until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("pixel changed or dropped while stalled");

    // A new pixel comes only from an advance request taken before it.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |->
            $past(req_valid && req_ready && req.kind == lrast_pkg::KIND_ADVANCE, 2))
        else $error("pixel without a matching advance request");

    // With the output register empty, the input side never stalls.
    assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid |-> req_ready)
        else $error("input stalled while the output register is empty");

    // In reset the output is empty and the input is open.
    assert property (@(posedge clk)
        !rst_n |-> !rsp_valid && req_ready)
        else $error("wrong handshake state in reset");

endmodule

bind line_rasterizer lrast_checker u_lrast_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);
